FILE: rtl/core/gtsc_pkg.sv
// Package of the GNSS time scale converter: operation codes, time constants,
// the month day-count table and the structs passed between pipeline modules.
// Depends on nothing.
package gtsc_pkg;

   typedef enum logic [2:0] {
      OP_MJD_TO_CAL = 3'd0,
      OP_CAL_TO_MJD = 3'd1,
      OP_GPS_TO_MJD = 3'd2,
      OP_MJD_TO_GPS = 3'd3,
      OP_GPS_TO_CAL = 3'd4,
      OP_CAL_TO_GPS = 3'd5
   } op_type;

   localparam logic [36:0] US_PER_DAY    = 37'd86400000000;
   localparam logic [31:0] US_PER_HOUR   = 32'd3600000000;
   localparam logic [25:0] US_PER_MIN    = 26'd60000000;
   localparam logic [15:0] GPS_EPOCH_MJD = 16'd44244;

   // Whole days before month k in the 30.6001 rule: floor(30.6001 * k).
   function automatic logic [8:0] month_base(input logic [4:0] k);
      case (k)
         5'd1:    return 9'd30;
         5'd2:    return 9'd61;
         5'd3:    return 9'd91;
         5'd4:    return 9'd122;
         5'd5:    return 9'd153;
         5'd6:    return 9'd183;
         5'd7:    return 9'd214;
         5'd8:    return 9'd244;
         5'd9:    return 9'd275;
         5'd10:   return 9'd306;
         5'd11:   return 9'd336;
         5'd12:   return 9'd367;
         5'd13:   return 9'd397;
         5'd14:   return 9'd428;
         5'd15:   return 9'd459;
         5'd16:   return 9'd489;
         default: return 9'd0;
      endcase
   endfunction

   typedef struct packed {
      logic               valid;
      op_type             op;
      logic signed [21:0] day;
      logic [36:0]        frac;
   } mjd_type;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [25:0] second_us;
      logic [15:0] week;
      logic [39:0] week_us;
      logic [17:0] mjd_day;
      logic [36:0] mjd_day_us;
      logic        out_of_range;
   } res_type;

endpackage

FILE: rtl/core/gnss_time_scale_converter.sv
// GNSS time scale converter: one result transfer for each request transfer,
// converting among calendar time, MJD with fraction of day and GPS week time.
// Depends on gtsc_pkg, gtsc_to_mjd and gtsc_from_mjd.
//
// The converter takes one request per clock while the result side does not
// stall: two stages bring the source to a day number and fraction of day, six
// stages derive calendar, week and MJD fields by reciprocal multiplication
// with one correction step each, and a final register holds the result. A
// stall on the result side holds the whole pipeline and stalls the request
// side in the same cycle; nothing is dropped or repeated. Results that leave
// the field ranges, and unknown operation codes, return out_of_range with all
// other fields zero.
module gnss_time_scale_converter
   import gtsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_operation,
   input  logic [11:0] req_cal_year,
   input  logic [3:0]  req_cal_month,
   input  logic [4:0]  req_cal_day,
   input  logic [4:0]  req_cal_hour,
   input  logic [5:0]  req_cal_minute,
   input  logic [25:0] req_cal_second_us,
   input  logic [15:0] req_gps_week,
   input  logic [39:0] req_gps_week_us,
   input  logic [17:0] req_mjd_day,
   input  logic [36:0] req_mjd_day_us,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [11:0] rsp_res_year,
   output logic [3:0]  rsp_res_month,
   output logic [4:0]  rsp_res_day,
   output logic [4:0]  rsp_res_hour,
   output logic [5:0]  rsp_res_minute,
   output logic [25:0] rsp_res_second_us,
   output logic [15:0] rsp_res_week,
   output logic [39:0] rsp_res_week_us,
   output logic [17:0] rsp_res_mjd_day,
   output logic [36:0] rsp_res_mjd_day_us,
   output logic        rsp_out_of_range
);

   logic    adv;
   mjd_type mjd;
   logic    res_valid;
   res_type res;
   logic    out_valid_ff;
   res_type out_ff;

   assign adv       = !(out_valid_ff && rsp_stall);
   assign req_stall = !adv;

   gtsc_to_mjd u_to_mjd (
      .clock             (clock),
      .reset             (reset),
      .adv               (adv),
      .req_valid         (req_valid),
      .req_operation     (req_operation),
      .req_cal_year      (req_cal_year),
      .req_cal_month     (req_cal_month),
      .req_cal_day       (req_cal_day),
      .req_cal_hour      (req_cal_hour),
      .req_cal_minute    (req_cal_minute),
      .req_cal_second_us (req_cal_second_us),
      .req_gps_week      (req_gps_week),
      .req_gps_week_us   (req_gps_week_us),
      .req_mjd_day       (req_mjd_day),
      .req_mjd_day_us    (req_mjd_day_us),
      .mjd               (mjd)
   );

   gtsc_from_mjd u_from_mjd (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .mjd       (mjd),
      .res_valid (res_valid),
      .res       (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= res_valid;
      end
      if (adv) begin
         out_ff <= res;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_res_year       = out_ff.year;
   assign rsp_res_month      = out_ff.month;
   assign rsp_res_day        = out_ff.day;
   assign rsp_res_hour       = out_ff.hour;
   assign rsp_res_minute     = out_ff.minute;
   assign rsp_res_second_us  = out_ff.second_us;
   assign rsp_res_week       = out_ff.week;
   assign rsp_res_week_us    = out_ff.week_us;
   assign rsp_res_mjd_day    = out_ff.mjd_day;
   assign rsp_res_mjd_day_us = out_ff.mjd_day_us;
   assign rsp_out_of_range   = out_ff.out_of_range;

   a_stall_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("request side not stalled while a result is held");

   a_oor_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |-> rsp_res_year == 12'd0 && rsp_res_week == 16'd0
         && rsp_res_mjd_day == 18'd0 && rsp_res_week_us == 40'd0)
      else $error("out of range result carries nonzero fields");

   a_cal_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_res_month != 4'd0 |-> rsp_res_month <= 4'd12
         && rsp_res_day != 5'd0 && rsp_res_hour <= 5'd23 && rsp_res_minute <= 6'd59)
      else $error("calendar result outside its ranges");

   a_mjd_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_res_mjd_day != 18'd0 |-> rsp_res_mjd_day >= 18'd15385
         && rsp_res_mjd_day <= 18'd197000 && rsp_res_mjd_day_us < 37'd86400000000)
      else $error("MJD result outside its ranges");

   a_week_us: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_res_week_us < 40'd604800000000)
      else $error("time of week reaches a full week");

endmodule

FILE: rtl/core/gtsc_to_mjd.sv
// Front pipeline of the converter: brings every source format to a day number
// and a fraction of day below one day, in two register stages.
// Depends on gtsc_pkg.
module gtsc_to_mjd
   import gtsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  logic        req_valid,
   input  logic [2:0]  req_operation,
   input  logic [11:0] req_cal_year,
   input  logic [3:0]  req_cal_month,
   input  logic [4:0]  req_cal_day,
   input  logic [4:0]  req_cal_hour,
   input  logic [5:0]  req_cal_minute,
   input  logic [25:0] req_cal_second_us,
   input  logic [15:0] req_gps_week,
   input  logic [39:0] req_gps_week_us,
   input  logic [17:0] req_mjd_day,
   input  logic [36:0] req_mjd_day_us,
   output mjd_type     mjd
);

   logic               cal_shift;
   logic signed [12:0] y_adj;
   logic [3:0]         m_adj;
   logic signed [21:0] y_days;
   logic [10:0]        y_quarter;
   logic [8:0]         m_base;
   logic signed [21:0] cal_day_num;
   logic [36:0]        cal_frac;
   logic [43:0]        gps_prod;
   logic [21:0]        gps_base;

   logic               a_valid_ff, a_valid_in;
   op_type             a_op_ff, a_op_in;
   logic signed [21:0] a_day_ff, a_day_in;
   logic [39:0]        a_frac_ff, a_frac_in;
   logic [3:0]         a_q_ff, a_q_in;

   logic [39:0]        b_rem;
   logic               b_carry;
   logic               b_valid_ff;
   op_type             b_op_ff;
   logic signed [21:0] b_day_ff, b_day_in;
   logic [36:0]        b_frac_ff, b_frac_in;

   assign cal_shift   = (req_cal_month <= 4'd2);
   assign y_adj       = $signed({1'b0, req_cal_year}) - $signed({12'd0, cal_shift});
   assign m_adj       = cal_shift ? req_cal_month + 4'd12 : req_cal_month;
   assign y_days      = 22'(y_adj) * 22'sd365;
   assign y_quarter   = y_adj[12] ? 11'd0 : y_adj[12:2];
   assign m_base      = month_base(5'(m_adj) + 5'd1);
   assign cal_day_num = y_days + $signed({11'd0, y_quarter}) + $signed({13'd0, m_base})
                      + $signed({17'd0, req_cal_day}) - 22'sd679019;
   assign cal_frac    = 37'(req_cal_hour) * 37'(US_PER_HOUR)
                      + 37'(req_cal_minute) * 37'(US_PER_MIN) + 37'(req_cal_second_us);
   assign gps_prod    = 44'(req_gps_week_us) * 44'd12;
   assign gps_base    = 22'(GPS_EPOCH_MJD) + 22'(req_gps_week) * 22'd7;

   always_comb begin
      a_valid_in = req_valid;
      a_op_in    = op_type'(req_operation);
      case (op_type'(req_operation))
         OP_CAL_TO_MJD, OP_CAL_TO_GPS: begin
            a_day_in  = cal_day_num;
            a_frac_in = 40'(cal_frac);
            a_q_in    = 4'd0;
         end
         OP_GPS_TO_MJD, OP_GPS_TO_CAL: begin
            a_day_in  = $signed(gps_base);
            a_frac_in = req_gps_week_us;
            a_q_in    = gps_prod[43:40];
         end
         default: begin
            a_day_in  = $signed({4'd0, req_mjd_day});
            a_frac_in = 40'(req_mjd_day_us);
            a_q_in    = 4'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= a_valid_in;
      end
      if (adv) begin
         a_op_ff   <= a_op_in;
         a_day_ff  <= a_day_in;
         a_frac_ff <= a_frac_in;
         a_q_ff    <= a_q_in;
      end
   end

   assign b_rem     = a_frac_ff - 40'(a_q_ff) * 40'(US_PER_DAY);
   assign b_carry   = (b_rem >= 40'(US_PER_DAY));
   assign b_day_in  = a_day_ff + $signed({18'd0, a_q_ff}) + $signed({21'd0, b_carry});
   assign b_frac_in = b_carry ? 37'(b_rem - 40'(US_PER_DAY)) : b_rem[36:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (adv) begin
         b_valid_ff <= a_valid_ff;
      end
      if (adv) begin
         b_op_ff   <= a_op_ff;
         b_day_ff  <= b_day_in;
         b_frac_ff <= b_frac_in;
      end
   end

   assign mjd.valid = b_valid_ff;
   assign mjd.op    = b_op_ff;
   assign mjd.day   = b_day_ff;
   assign mjd.frac  = b_frac_ff;

endmodule

FILE: rtl/core/gtsc_from_mjd.sv
// Back pipeline of the converter: from a day number and fraction of day builds
// the calendar, GPS week and MJD results in six stages and selects one.
// Depends on gtsc_pkg.
module gtsc_from_mjd
   import gtsc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    adv,
   input  mjd_type mjd,
   output logic    res_valid,
   output res_type res
);

   logic [21:0]        s1_b;
   logic [28:0]        s1_n;
   logic [42:0]        s1_cprod;
   logic [42:0]        s1_hprod;
   logic signed [21:0] s1_dd;
   logic [37:0]        s1_wprod;

   logic               f1_valid_ff;
   op_type             f1_op_ff;
   logic signed [21:0] f1_day_ff;
   logic [36:0]        f1_frac_ff;
   logic [21:0]        f1_b_ff;
   logic [28:0]        f1_n_ff;
   logic [12:0]        f1_cq_ff, f1_cq_in;
   logic [4:0]         f1_hq_ff, f1_hq_in;
   logic [19:0]        f1_du_ff, f1_du_in;
   logic               f1_neg_ff, f1_neg_in;
   logic [17:0]        f1_wq_ff, f1_wq_in;
   logic               f1_mok_ff, f1_mok_in;

   logic [28:0]        s2_cr;
   logic [36:0]        s2_hr;
   logic               s2_hc;
   logic [19:0]        s2_wr;
   logic               s2_wc;

   logic               f2_valid_ff;
   op_type             f2_op_ff;
   logic signed [21:0] f2_day_ff;
   logic [36:0]        f2_frac_ff;
   logic [21:0]        f2_b_ff;
   logic [12:0]        f2_c_ff, f2_c_in;
   logic [4:0]         f2_hour_ff, f2_hour_in;
   logic [31:0]        f2_hrem_ff, f2_hrem_in;
   logic [17:0]        f2_week_ff, f2_week_in;
   logic [2:0]         f2_wrem_ff, f2_wrem_in;
   logic               f2_neg_ff;
   logic               f2_mok_ff;

   logic [21:0]        s3_cd;
   logic [38:0]        s3_mprod;

   logic               f3_valid_ff;
   op_type             f3_op_ff;
   logic signed [21:0] f3_day_ff;
   logic [36:0]        f3_frac_ff;
   logic [12:0]        f3_c_ff;
   logic [9:0]         f3_x_ff, f3_x_in;
   logic [4:0]         f3_hour_ff;
   logic [31:0]        f3_hrem_ff;
   logic [5:0]         f3_mq_ff, f3_mq_in;
   logic [17:0]        f3_week_ff;
   logic [39:0]        f3_wus_ff, f3_wus_in;
   logic               f3_gok_ff, f3_gok_in;
   logic               f3_mok_ff;

   logic [31:0]        s4_mr;
   logic               s4_mc;

   logic               f4_valid_ff;
   op_type             f4_op_ff;
   logic signed [21:0] f4_day_ff;
   logic [36:0]        f4_frac_ff;
   logic [12:0]        f4_c_ff;
   logic [9:0]         f4_x_ff;
   logic [22:0]        f4_n2_ff, f4_n2_in;
   logic [4:0]         f4_hour_ff;
   logic [5:0]         f4_min_ff, f4_min_in;
   logic [25:0]        f4_sec_ff, f4_sec_in;
   logic [17:0]        f4_week_ff;
   logic [39:0]        f4_wus_ff;
   logic               f4_gok_ff;
   logic               f4_mok_ff;

   logic [27:0]        s5_eprod;

   logic               f5_valid_ff;
   op_type             f5_op_ff;
   logic signed [21:0] f5_day_ff;
   logic [36:0]        f5_frac_ff;
   logic [12:0]        f5_c_ff;
   logic [9:0]         f5_x_ff;
   logic [22:0]        f5_n2_ff;
   logic [4:0]         f5_eq_ff, f5_eq_in;
   logic [4:0]         f5_hour_ff;
   logic [5:0]         f5_min_ff;
   logic [25:0]        f5_sec_ff;
   logic [17:0]        f5_week_ff;
   logic [39:0]        f5_wus_ff;
   logic               f5_gok_ff;
   logic               f5_mok_ff;

   logic [22:0]        s6_er;

   logic               f6_valid_ff;
   op_type             f6_op_ff;
   logic signed [21:0] f6_day_ff;
   logic [36:0]        f6_frac_ff;
   logic [12:0]        f6_c_ff;
   logic [9:0]         f6_x_ff;
   logic [4:0]         f6_e_ff, f6_e_in;
   logic [4:0]         f6_hour_ff;
   logic [5:0]         f6_min_ff;
   logic [25:0]        f6_sec_ff;
   logic [17:0]        f6_week_ff;
   logic [39:0]        f6_wus_ff;
   logic               f6_gok_ff;
   logic               f6_mok_ff;

   logic [8:0]         e_base;
   logic signed [10:0] cal_day;
   logic signed [5:0]  cal_month;
   logic signed [5:0]  month_p7;
   logic [1:0]         year_adj;
   logic signed [14:0] cal_year;
   logic               cal_ok;

   // Stage 1: coarse quotients by reciprocal multiplication, MJD range check.
   assign s1_b      = 22'(mjd.day) + 22'd2401538;
   assign s1_n      = 29'(29'(s1_b) * 29'd100 - 29'd12210);
   assign s1_cprod  = 43'(s1_n) * 43'd14698;
   assign s1_hprod  = 43'(mjd.frac) * 43'd38;
   assign s1_dd     = mjd.day - 22'sd44244;
   assign s1_wprod  = 38'(s1_dd[19:0]) * 38'd149796;
   assign f1_cq_in  = s1_cprod[41:29];
   assign f1_hq_in  = s1_hprod[41:37];
   assign f1_du_in  = s1_dd[19:0];
   assign f1_neg_in = s1_dd[21];
   assign f1_wq_in  = s1_wprod[37:20];
   assign f1_mok_in = (mjd.day >= 22'sd15385) && (mjd.day <= 22'sd197000);

   // Stage 2: one correction step for each quotient.
   assign s2_cr      = f1_n_ff - 29'(f1_cq_ff) * 29'd36525;
   assign f2_c_in    = (s2_cr >= 29'd36525) ? f1_cq_ff + 13'd1 : f1_cq_ff;
   assign s2_hr      = f1_frac_ff - 37'(f1_hq_ff) * 37'(US_PER_HOUR);
   assign s2_hc      = (s2_hr >= 37'(US_PER_HOUR));
   assign f2_hour_in = f1_hq_ff + 5'(s2_hc);
   assign f2_hrem_in = s2_hc ? 32'(s2_hr - 37'(US_PER_HOUR)) : s2_hr[31:0];
   assign s2_wr      = f1_du_ff - 20'(f1_wq_ff) * 20'd7;
   assign s2_wc      = (s2_wr >= 20'd7);
   assign f2_week_in = f1_wq_ff + 18'(s2_wc);
   assign f2_wrem_in = s2_wc ? 3'(s2_wr - 20'd7) : s2_wr[2:0];

   // Stage 3: day within the Julian year, minute estimate, time of week, GPS range check.
   assign s3_cd     = 22'(f2_c_ff) * 22'd365 + 22'(f2_c_ff[12:2]);
   assign f3_x_in   = 10'(f2_b_ff - s3_cd);
   assign s3_mprod  = 39'(f2_hrem_ff) * 39'd71;
   assign f3_mq_in  = s3_mprod[37:32];
   assign f3_wus_in = 40'(f2_wrem_ff) * 40'(US_PER_DAY) + 40'(f2_frac_ff);
   assign f3_gok_in = !f2_neg_ff && (f2_week_ff <= 18'd65535);

   // Stage 4: scaled day for the month search, minute correction.
   assign f4_n2_in  = 23'(f3_x_ff) * 23'd10000;
   assign s4_mr     = f3_hrem_ff - 32'(f3_mq_ff) * 32'(US_PER_MIN);
   assign s4_mc     = (s4_mr >= 32'(US_PER_MIN));
   assign f4_min_in = f3_mq_ff + 6'(s4_mc);
   assign f4_sec_in = s4_mc ? 26'(s4_mr - 32'(US_PER_MIN)) : s4_mr[25:0];

   // Stage 5: month estimate.
   assign s5_eprod = 28'(f4_n2_ff) * 28'd27;
   assign f5_eq_in = s5_eprod[27:23];

   // Stage 6: month correction.
   assign s6_er   = f5_n2_ff - 23'(f5_eq_ff) * 23'd306001;
   assign f6_e_in = (s6_er >= 23'd306001) ? f5_eq_ff + 5'd1 : f5_eq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
         f3_valid_ff <= 1'b0;
         f4_valid_ff <= 1'b0;
         f5_valid_ff <= 1'b0;
         f6_valid_ff <= 1'b0;
      end else if (adv) begin
         f1_valid_ff <= mjd.valid;
         f2_valid_ff <= f1_valid_ff;
         f3_valid_ff <= f2_valid_ff;
         f4_valid_ff <= f3_valid_ff;
         f5_valid_ff <= f4_valid_ff;
         f6_valid_ff <= f5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f1_op_ff   <= mjd.op;
         f1_day_ff  <= mjd.day;
         f1_frac_ff <= mjd.frac;
         f1_b_ff    <= s1_b;
         f1_n_ff    <= s1_n;
         f1_cq_ff   <= f1_cq_in;
         f1_hq_ff   <= f1_hq_in;
         f1_du_ff   <= f1_du_in;
         f1_neg_ff  <= f1_neg_in;
         f1_wq_ff   <= f1_wq_in;
         f1_mok_ff  <= f1_mok_in;

         f2_op_ff   <= f1_op_ff;
         f2_day_ff  <= f1_day_ff;
         f2_frac_ff <= f1_frac_ff;
         f2_b_ff    <= f1_b_ff;
         f2_c_ff    <= f2_c_in;
         f2_hour_ff <= f2_hour_in;
         f2_hrem_ff <= f2_hrem_in;
         f2_week_ff <= f2_week_in;
         f2_wrem_ff <= f2_wrem_in;
         f2_neg_ff  <= f1_neg_ff;
         f2_mok_ff  <= f1_mok_ff;

         f3_op_ff   <= f2_op_ff;
         f3_day_ff  <= f2_day_ff;
         f3_frac_ff <= f2_frac_ff;
         f3_c_ff    <= f2_c_ff;
         f3_x_ff    <= f3_x_in;
         f3_hour_ff <= f2_hour_ff;
         f3_hrem_ff <= f2_hrem_ff;
         f3_mq_ff   <= f3_mq_in;
         f3_week_ff <= f2_week_ff;
         f3_wus_ff  <= f3_wus_in;
         f3_gok_ff  <= f3_gok_in;
         f3_mok_ff  <= f2_mok_ff;

         f4_op_ff   <= f3_op_ff;
         f4_day_ff  <= f3_day_ff;
         f4_frac_ff <= f3_frac_ff;
         f4_c_ff    <= f3_c_ff;
         f4_x_ff    <= f3_x_ff;
         f4_n2_ff   <= f4_n2_in;
         f4_hour_ff <= f3_hour_ff;
         f4_min_ff  <= f4_min_in;
         f4_sec_ff  <= f4_sec_in;
         f4_week_ff <= f3_week_ff;
         f4_wus_ff  <= f3_wus_ff;
         f4_gok_ff  <= f3_gok_ff;
         f4_mok_ff  <= f3_mok_ff;

         f5_op_ff   <= f4_op_ff;
         f5_day_ff  <= f4_day_ff;
         f5_frac_ff <= f4_frac_ff;
         f5_c_ff    <= f4_c_ff;
         f5_x_ff    <= f4_x_ff;
         f5_n2_ff   <= f4_n2_ff;
         f5_eq_ff   <= f5_eq_in;
         f5_hour_ff <= f4_hour_ff;
         f5_min_ff  <= f4_min_ff;
         f5_sec_ff  <= f4_sec_ff;
         f5_week_ff <= f4_week_ff;
         f5_wus_ff  <= f4_wus_ff;
         f5_gok_ff  <= f4_gok_ff;
         f5_mok_ff  <= f4_mok_ff;

         f6_op_ff   <= f5_op_ff;
         f6_day_ff  <= f5_day_ff;
         f6_frac_ff <= f5_frac_ff;
         f6_c_ff    <= f5_c_ff;
         f6_x_ff    <= f5_x_ff;
         f6_e_ff    <= f6_e_in;
         f6_hour_ff <= f5_hour_ff;
         f6_min_ff  <= f5_min_ff;
         f6_sec_ff  <= f5_sec_ff;
         f6_week_ff <= f5_week_ff;
         f6_wus_ff  <= f5_wus_ff;
         f6_gok_ff  <= f5_gok_ff;
         f6_mok_ff  <= f5_mok_ff;
      end
   end

   assign e_base    = month_base(f6_e_ff);
   assign cal_day   = $signed({1'b0, f6_x_ff}) - $signed({2'b0, e_base});
   assign cal_month = (f6_e_ff >= 5'd14) ? $signed({1'b0, f6_e_ff}) - 6'sd13
                                         : $signed({1'b0, f6_e_ff}) - 6'sd1;
   assign month_p7  = cal_month + 6'sd7;
   assign year_adj  = (month_p7 >= 6'sd20) ? 2'd2 : ((month_p7 >= 6'sd10) ? 2'd1 : 2'd0);
   assign cal_year  = $signed({2'b0, f6_c_ff}) - 15'sd4715 - $signed({13'd0, year_adj});
   assign cal_ok    = (cal_year >= 15'sd1901) && (cal_year <= 15'sd2399)
                   && (cal_month >= 6'sd1) && (cal_month <= 6'sd12)
                   && (cal_day >= 11'sd1) && (cal_day <= 11'sd31);

   always_comb begin
      res = '0;
      case (f6_op_ff)
         OP_MJD_TO_CAL, OP_GPS_TO_CAL: begin
            res.year      = cal_year[11:0];
            res.month     = cal_month[3:0];
            res.day       = cal_day[4:0];
            res.hour      = f6_hour_ff;
            res.minute    = f6_min_ff;
            res.second_us = f6_sec_ff;
            res.out_of_range = !cal_ok;
         end
         OP_CAL_TO_MJD, OP_GPS_TO_MJD: begin
            res.mjd_day      = f6_day_ff[17:0];
            res.mjd_day_us   = f6_frac_ff;
            res.out_of_range = !f6_mok_ff;
         end
         OP_MJD_TO_GPS, OP_CAL_TO_GPS: begin
            res.week         = f6_week_ff[15:0];
            res.week_us      = f6_wus_ff;
            res.out_of_range = !f6_gok_ff;
         end
         default: begin
            res.out_of_range = 1'b1;
         end
      endcase
      if (res.out_of_range) begin
         res = '0;
         res.out_of_range = 1'b1;
      end
   end

   assign res_valid = f6_valid_ff;

endmodule

FILE: dv/tb.sv
// Testbench of gnss_time_scale_converter: random and directed conversion requests,
// results checked in order against a predictor held in a small scoreboard class.
// Depends on gtsc_pkg and the converter RTL.
module tb
   import gtsc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [2:0]  op;
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [25:0] second_us;
      logic [15:0] week;
      logic [39:0] week_us;
      logic [17:0] mjd;
      logic [36:0] mjd_us;
   } request_type;

   localparam longint USD = 64'd86400000000;
   localparam longint USW = 7 * USD;
   localparam longint USH = 64'd3600000000;
   localparam longint USM = 64'd60000000;
   localparam longint EPOCH = 44244;

   class conversion_scoreboard;
      res_type pending[$];
      int      errors = 0;

      function automatic bit to_cal(longint d, longint f, inout res_type r);
         longint a, b, c, dd, e, dy, mo, yr, rem;
         d += f / USD;
         f = f % USD;
         a = d + 2400001;
         b = a + 1537;
         c = (100 * b - 12210) / 36525;
         dd = (36525 * c) / 100;
         e = ((b - dd) * 10000) / 306001;
         dy = b - dd - (306001 * e) / 10000;
         mo = e - 1 - 12 * (e / 14);
         yr = c - 4715 - (7 + mo) / 10;
         r.year = 12'(yr);
         r.month = 4'(mo);
         r.day = 5'(dy);
         r.hour = 5'(f / USH);
         rem = f % USH;
         r.minute = 6'(rem / USM);
         r.second_us = 26'(rem % USM);
         return yr >= 1901 && yr <= 2399 && mo >= 1 && mo <= 12 && dy >= 1 && dy <= 31;
      endfunction

      function automatic void from_cal(request_type q, output longint d, output longint f);
         longint y, m;
         y = longint'(q.year);
         m = longint'(q.month);
         if (m <= 2) begin
            y -= 1;
            m += 12;
         end
         d = (36525 * y) / 100 + (306001 * (m + 1)) / 10000 + longint'(q.day) - 679019;
         f = longint'(q.hour) * USH + longint'(q.minute) * USM + longint'(q.second_us);
         d += f / USD;
         f = f % USD;
      endfunction

      function automatic void from_gps(request_type q, output longint d, output longint f);
         longint w;
         w = longint'(q.week_us);
         d = EPOCH + longint'(q.week) * 7 + w / USD;
         f = w % USD;
      endfunction

      function automatic bit to_gps(longint d, longint f, inout res_type r);
         longint total, wk;
         total = (d - EPOCH) * USD + f;
         if (total < 0) return 0;
         wk = total / USW;
         r.week = 16'(wk);
         r.week_us = 40'(total - wk * USW);
         return wk <= 65535;
      endfunction

      function automatic res_type convert(request_type q);
         res_type r;
         longint  d, f;
         bit      ok;
         r = '0;
         ok = 0;
         case (q.op)
            OP_MJD_TO_CAL: ok = to_cal(longint'(q.mjd), longint'(q.mjd_us), r);
            OP_CAL_TO_MJD, OP_GPS_TO_MJD: begin
               if (q.op == OP_CAL_TO_MJD) from_cal(q, d, f);
               else from_gps(q, d, f);
               r.mjd_day = 18'(d);
               r.mjd_day_us = 37'(f);
               ok = d >= 15385 && d <= 197000;
            end
            OP_MJD_TO_GPS: begin
               d = longint'(q.mjd);
               f = longint'(q.mjd_us);
               d += f / USD;
               f = f % USD;
               ok = to_gps(d, f, r);
            end
            OP_GPS_TO_CAL: begin
               from_gps(q, d, f);
               ok = to_cal(d, f, r);
            end
            OP_CAL_TO_GPS: begin
               from_cal(q, d, f);
               ok = to_gps(d, f, r);
            end
            default: ok = 0;
         endcase
         if (!ok) begin
            r = '0;
            r.out_of_range = 1'b1;
         end
         return r;
      endfunction

      function void note_request(request_type q);
         pending.push_back(convert(q));
      endfunction

      function void cmp(string name, longint e, longint a);
         if (e != a) begin
            $error("%s: expected %0d, actual %0d", name, e, a);
            errors++;
         end
      endfunction

      function void check_result(res_type a);
         res_type e;
         if (pending.size() == 0) begin
            $error("result transfer with no request pending");
            errors++;
            return;
         end
         e = pending.pop_front();
         cmp("res_year", e.year, a.year);
         cmp("res_month", e.month, a.month);
         cmp("res_day", e.day, a.day);
         cmp("res_hour", e.hour, a.hour);
         cmp("res_minute", e.minute, a.minute);
         cmp("res_second_us", e.second_us, a.second_us);
         cmp("res_week", e.week, a.week);
         cmp("res_week_us", e.week_us, a.week_us);
         cmp("res_mjd_day", e.mjd_day, a.mjd_day);
         cmp("res_mjd_day_us", e.mjd_day_us, a.mjd_day_us);
         cmp("out_of_range", e.out_of_range, a.out_of_range);
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [2:0]  req_operation = '0;
   logic [11:0] req_cal_year = '0;
   logic [3:0]  req_cal_month = '0;
   logic [4:0]  req_cal_day = '0;
   logic [4:0]  req_cal_hour = '0;
   logic [5:0]  req_cal_minute = '0;
   logic [25:0] req_cal_second_us = '0;
   logic [15:0] req_gps_week = '0;
   logic [39:0] req_gps_week_us = '0;
   logic [17:0] req_mjd_day = '0;
   logic [36:0] req_mjd_day_us = '0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   res_type     rsp;

   gnss_time_scale_converter i_dut (
      .clock, .reset, .req_valid, .req_stall, .req_operation, .req_cal_year,
      .req_cal_month, .req_cal_day, .req_cal_hour, .req_cal_minute,
      .req_cal_second_us, .req_gps_week, .req_gps_week_us, .req_mjd_day,
      .req_mjd_day_us, .rsp_valid, .rsp_stall,
      .rsp_res_year(rsp.year), .rsp_res_month(rsp.month), .rsp_res_day(rsp.day),
      .rsp_res_hour(rsp.hour), .rsp_res_minute(rsp.minute),
      .rsp_res_second_us(rsp.second_us), .rsp_res_week(rsp.week),
      .rsp_res_week_us(rsp.week_us), .rsp_res_mjd_day(rsp.mjd_day),
      .rsp_res_mjd_day_us(rsp.mjd_day_us), .rsp_out_of_range(rsp.out_of_range)
   );

   conversion_scoreboard board = new();
   int  phase = 0;
   bit  held_off = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("Mismatches found");
      $finish;
   end

   function automatic int sender_idle_pct();
      return phase == 0 ? 38 : phase == 1 ? 67 : 0;
   endfunction

   function automatic int receiver_idle_pct();
      return phase == 0 ? 67 : phase == 1 ? 38 : 0;
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (phase == 2 && !held_off) begin
            held_off = 1;
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
         end
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct());
      end
   end

   always @(negedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp);
   end

   task automatic send_request(request_type q);
      int gap;
      bit taken;
      gap = 0;
      if ($urandom_range(99) < sender_idle_pct()) gap = $urandom_range(1, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= q.op;
      req_cal_year <= q.year;
      req_cal_month <= q.month;
      req_cal_day <= q.day;
      req_cal_hour <= q.hour;
      req_cal_minute <= q.minute;
      req_cal_second_us <= q.second_us;
      req_gps_week <= q.week;
      req_gps_week_us <= q.week_us;
      req_mjd_day <= q.mjd;
      req_mjd_day_us <= q.mjd_us;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      board.note_request(q);
   endtask

   function automatic request_type random_request();
      request_type q;
      q.op = 3'($urandom_range(99) < 4 ? $urandom_range(7) : $urandom_range(5));
      if ($urandom_range(99) < 12) begin
         q.year = 12'($urandom);
         q.month = 4'($urandom);
         q.day = 5'($urandom);
         q.hour = 5'($urandom);
         q.minute = 6'($urandom);
         q.second_us = 26'($urandom);
         q.week = 16'($urandom);
         q.week_us = 40'({$urandom, $urandom});
         q.mjd = 18'($urandom);
         q.mjd_us = 37'({$urandom, $urandom});
      end else begin
         q.year = 12'($urandom_range(1901, 2399));
         q.month = 4'($urandom_range(1, 12));
         q.day = 5'($urandom_range(1, 31));
         q.hour = 5'($urandom_range(23));
         q.minute = 6'($urandom_range(59));
         q.second_us = 26'($urandom_range(59999999));
         q.week = 16'($urandom_range(99) < 90 ? $urandom_range(21800) : $urandom);
         q.week_us = 40'({$urandom, $urandom} % 64'd604800000000);
         q.mjd = 18'($urandom_range(15385, 197000));
         q.mjd_us = 37'({$urandom, $urandom} % 64'd86400000000);
      end
      return q;
   endfunction

   function automatic request_type make_request(int op, int y, int mo, int d, int h, int mi,
                                                longint s, int w, longint wus, int mjd,
                                                longint mus);
      request_type q;
      q.op = 3'(op);
      q.year = 12'(y);
      q.month = 4'(mo);
      q.day = 5'(d);
      q.hour = 5'(h);
      q.minute = 6'(mi);
      q.second_us = 26'(s);
      q.week = 16'(w);
      q.week_us = 40'(wus);
      q.mjd = 18'(mjd);
      q.mjd_us = 37'(mus);
      return q;
   endfunction

   initial begin
      int wait_cycles;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      send_request(make_request(OP_MJD_TO_CAL, 0, 0, 0, 0, 0, 0, 0, 0, 15385, 0));
      send_request(make_request(OP_MJD_TO_CAL, 0, 0, 0, 0, 0, 0, 0, 0, 197000,
                                64'd86399999999));
      send_request(make_request(OP_MJD_TO_CAL, 0, 0, 0, 0, 0, 0, 0, 0, 262143,
                                64'd137438953471));
      send_request(make_request(OP_MJD_TO_CAL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_request(OP_MJD_TO_GPS, 0, 0, 0, 0, 0, 0, 0, 0, 44243,
                                64'd86399999999));
      send_request(make_request(OP_MJD_TO_GPS, 0, 0, 0, 0, 0, 0, 0, 0, 44244, 0));
      send_request(make_request(OP_MJD_TO_GPS, 0, 0, 0, 0, 0, 0, 0, 0, 262143,
                                64'd137438953471));
      send_request(make_request(OP_CAL_TO_MJD, 1901, 1, 1, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_request(OP_CAL_TO_MJD, 2399, 12, 31, 23, 59, 59999999,
                                0, 0, 0, 0));
      send_request(make_request(OP_CAL_TO_MJD, 2000, 0, 0, 31, 63, 67108863,
                                0, 0, 0, 0));
      send_request(make_request(OP_CAL_TO_MJD, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_request(OP_CAL_TO_GPS, 1980, 1, 6, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_request(OP_CAL_TO_GPS, 1980, 1, 5, 23, 59, 59999999,
                                0, 0, 0, 0));
      send_request(make_request(OP_CAL_TO_GPS, 2020, 13, 0, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_request(OP_CAL_TO_GPS, 4095, 15, 31, 31, 63, 67108863,
                                0, 0, 0, 0));
      send_request(make_request(OP_GPS_TO_MJD, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_request(OP_GPS_TO_MJD, 0, 0, 0, 0, 0, 0, 65535,
                                64'd1099511627775, 0, 0));
      send_request(make_request(OP_GPS_TO_CAL, 0, 0, 0, 0, 0, 0, 0, 64'd604799999999,
                                0, 0));
      send_request(make_request(OP_GPS_TO_CAL, 0, 0, 0, 0, 0, 0, 21822, 0, 0, 0));
      send_request(make_request(OP_GPS_TO_CAL, 0, 0, 0, 0, 0, 0, 65535,
                                64'd1099511627775, 0, 0));
      send_request(make_request(6, 2000, 1, 1, 0, 0, 0, 1, 1, 50000, 1));
      send_request(make_request(7, 2000, 1, 1, 0, 0, 0, 1, 1, 50000, 1));
      for (int n = 0; n < 1530; n++) begin
         phase = n < 510 ? 0 : n < 1020 ? 1 : 2;
         send_request(random_request());
      end
      req_valid <= 1'b0;
      wait_cycles = 0;
      while (board.pending.size() != 0 && wait_cycles < 100000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (20) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
